@@ sv/wmsp_pkg.sv @@
// shared constants, types and register codes for the window mode seed picker
`default_nettype none

package wmsp_pkg;

    // window geometry
    localparam int SUBSAMPLE_STEP = 4;
    localparam int MAX_COLUMNS    = 64;
    localparam int MAX_ROWS       = 16;

    // field widths
    localparam int PIX_W   = 8;
    localparam int BINS    = 1 << PIX_W;
    localparam int WCOL_W  = 7;
    localparam int OFS_W   = 11;
    localparam int SEED_W  = 12;
    localparam int COUNT_W = 11;
    localparam int CFG_W   = 11;

    // derived counter and position widths
    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int POS_W  = $clog2(MAX_ROWS * MAX_COLUMNS);
    localparam int SIDX_W = $clog2(MAX_ROWS * MAX_COLUMNS + 1);

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_WINDOW_COLUMNS = 2'd0,
        CFG_OFFSET_X       = 2'd1,
        CFG_OFFSET_Y       = 2'd2
    } cfg_index_t;

    // raster position of one sample, taken at acceptance
    typedef struct packed {
        logic             counted;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] sidx;
    } pos_info_t;

    // one histogram bin entry
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [POS_W-1:0]   first;
    } bin_t;

    // update stage status toward the top level
    typedef struct packed {
        logic valid;
        logic last;
    } stage_t;

    // running mode after the item in the update stage
    typedef struct packed {
        logic [PIX_W-1:0]   value;
        logic [COUNT_W-1:0] count;
        logic [POS_W-1:0]   pos;
    } mode_t;

endpackage

`default_nettype wire

@@ sv/wmsp_position.sv @@
// raster position counters of the current window
`default_nettype none

module wmsp_position
    import wmsp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic              last_sample,
    input  wire logic [WCOL_W-1:0] window_columns,
    output pos_info_t              info
);

    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [SIDX_W-1:0] sidx_reg;
    logic [WCOL_W-1:0] cols_eff;
    logic [WCOL_W-1:0] col_plus;
    logic              counted;

    // clamp the column register into its usable range
    always_comb
    begin
        if (window_columns == '0)
            cols_eff = WCOL_W'(1);
        else if (window_columns > WCOL_W'(MAX_COLUMNS))
            cols_eff = WCOL_W'(MAX_COLUMNS);
        else
            cols_eff = window_columns;
    end

    assign col_plus = WCOL_W'(col_reg) + WCOL_W'(1);
    assign counted  = (row_reg < ROW_W'(MAX_ROWS));

    // position of the sample being accepted now
    assign info.counted = counted;
    assign info.pos     = {row_reg[POS_W-COL_W-1:0], col_reg};
    assign info.sidx    = sidx_reg[POS_W-1:0];

    // step the raster position, restart after the final sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            sidx_reg <= '0;
        end
        else if (accept)
        begin
            if (last_sample)
            begin
                col_reg  <= '0;
                row_reg  <= '0;
                sidx_reg <= '0;
            end
            else if (counted)
            begin
                sidx_reg <= sidx_reg + SIDX_W'(1);
                if (col_plus >= cols_eff)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_plus[COL_W-1:0];
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/wmsp_hist.sv @@
// histogram memory, bin update stage and running mode tracking
`default_nettype none

module wmsp_hist
    import wmsp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [PIX_W-1:0] pixel_value,
    input  wire logic             last_sample,
    input  wire pos_info_t        info,
    input  wire logic             fire,
    output stage_t                stage,
    output mode_t                 mode
);

    bin_t               mem [BINS];
    bin_t               rd_reg;
    bin_t               hit_data_reg;
    logic               hit_reg;
    logic [BINS-1:0]    valid_reg;

    logic               s1_valid_reg;
    logic               s1_last_reg;
    logic [PIX_W-1:0]   s1_pv_reg;
    pos_info_t          s1_info_reg;

    logic [PIX_W-1:0]   best_value_reg;
    logic [COUNT_W-1:0] best_count_reg;
    logic [POS_W-1:0]   best_first_reg;
    logic [POS_W-1:0]   best_pos_reg;

    bin_t               old_bin;
    bin_t               new_bin;
    logic               bin_seen;
    logic               take;
    logic               wr_en;

    // current bin contents, bypassing a write that raced the read
    assign bin_seen = valid_reg[s1_pv_reg];
    assign old_bin  = hit_reg ? hit_data_reg : rd_reg;

    always_comb
    begin
        if (bin_seen)
        begin
            new_bin.count = old_bin.count + COUNT_W'(1);
            new_bin.first = old_bin.first;
        end
        else
        begin
            new_bin.count = COUNT_W'(1);
            new_bin.first = s1_info_reg.sidx;
        end
    end

    // higher count wins, on equal count the earlier first occurrence
    assign take = s1_info_reg.counted &&
                  ((new_bin.count > best_count_reg) ||
                   ((new_bin.count == best_count_reg) && (new_bin.first < best_first_reg)));

    assign wr_en = fire && s1_info_reg.counted;

    // mode including the item in the update stage
    always_comb
    begin
        if (take)
        begin
            mode.value = s1_pv_reg;
            mode.count = new_bin.count;
            mode.pos   = s1_info_reg.pos;
        end
        else
        begin
            mode.value = best_value_reg;
            mode.count = best_count_reg;
            mode.pos   = best_pos_reg;
        end
    end

    assign stage.valid = s1_valid_reg;
    assign stage.last  = s1_last_reg;

    // bin memory: one write from the update stage, one registered read at acceptance
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[s1_pv_reg] <= new_bin;
        if (accept)
        begin
            rd_reg       <= mem[pixel_value];
            hit_data_reg <= new_bin;
            s1_pv_reg    <= pixel_value;
            s1_info_reg  <= info;
            s1_last_reg  <= last_sample;
        end
    end

    // update stage occupancy and read bypass flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                hit_reg      <= wr_en && (s1_pv_reg == pixel_value);
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // bin valid bits and running mode, cleared at the end of a window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            best_value_reg <= '0;
            best_count_reg <= '0;
            best_first_reg <= '0;
            best_pos_reg   <= '0;
        end
        else if (fire)
        begin
            if (s1_last_reg)
            begin
                valid_reg      <= '0;
                best_value_reg <= '0;
                best_count_reg <= '0;
                best_first_reg <= '0;
                best_pos_reg   <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[s1_pv_reg] <= 1'b1;
                if (take)
                begin
                    best_value_reg <= s1_pv_reg;
                    best_count_reg <= new_bin.count;
                    best_first_reg <= new_bin.first;
                    best_pos_reg   <= s1_info_reg.pos;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/window_mode_seed_picker.sv @@
// result: the transaction that carries last_sample passes the update stage, then the result register loads
// throughput: one sample per cycle, the bin memory takes one read and one write each cycle
// input stalls only while a window result waits at the output and the next final sample
// reaches the update stage
// reset: counters, bin valid bits and mode clear at once; bin memory needs no clearing pass
`default_nettype none

module window_mode_seed_picker
    import wmsp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [PIX_W-1:0]   pixel_value,
    input  wire logic               last_sample,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [SEED_W-1:0]       seed_x,
    output logic [SEED_W-1:0]       seed_y,
    output logic [PIX_W-1:0]        mode_value,
    output logic [COUNT_W-1:0]      mode_count
);

    logic [WCOL_W-1:0]  window_columns_reg;
    logic [OFS_W-1:0]   offset_x_reg;
    logic [OFS_W-1:0]   offset_y_reg;

    logic               out_valid_reg;
    logic [SEED_W-1:0]  seed_x_reg;
    logic [SEED_W-1:0]  seed_y_reg;
    logic [PIX_W-1:0]   mode_value_reg;
    logic [COUNT_W-1:0] mode_count_reg;

    logic               accept;
    logic               fire;
    logic               load;
    pos_info_t          info;
    stage_t             stage;
    mode_t              mode;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_columns_reg <= WCOL_W'(40);
            offset_x_reg       <= OFS_W'(240);
            offset_y_reg       <= OFS_W'(315);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_WINDOW_COLUMNS: window_columns_reg <= cfg_data[WCOL_W-1:0];
                CFG_OFFSET_X:       offset_x_reg       <= cfg_data[OFS_W-1:0];
                CFG_OFFSET_Y:       offset_y_reg       <= cfg_data[OFS_W-1:0];
                default:            ;
            endcase
        end
    end

    // update stage moves on unless its final sample finds the output still full
    assign fire     = stage.valid && !(stage.last && out_valid_reg && out_stall);
    assign in_stall = stage.valid && !fire;
    assign accept   = in_valid && !in_stall;
    assign load     = fire && stage.last;

    wmsp_position u_position (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .last_sample    (last_sample),
        .window_columns (window_columns_reg),
        .info           (info)
    );

    wmsp_hist u_hist (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .pixel_value (pixel_value),
        .last_sample (last_sample),
        .info        (info),
        .fire        (fire),
        .stage       (stage),
        .mode        (mode)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // seed coordinate of the last occurrence of the mode
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            seed_x_reg     <= SEED_W'(mode.pos[COL_W-1:0]) * SEED_W'(SUBSAMPLE_STEP)
                              + SEED_W'(offset_x_reg);
            seed_y_reg     <= SEED_W'(mode.pos[POS_W-1:COL_W]) * SEED_W'(SUBSAMPLE_STEP)
                              + SEED_W'(offset_y_reg);
            mode_value_reg <= mode.value;
            mode_count_reg <= mode.count;
        end
    end

    assign out_valid  = out_valid_reg;
    assign seed_x     = seed_x_reg;
    assign seed_y     = seed_y_reg;
    assign mode_value = mode_value_reg;
    assign mode_count = mode_count_reg;

    // input only stalls behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && stage.last))
        else $error("input stalled without a waiting result");

    // every window counts its first sample
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mode_count != '0))
        else $error("result with zero mode count");

    // a final sample reaches the update stage on the next cycle
    a_last_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_sample) |=> (stage.valid && stage.last))
        else $error("final sample lost before the update stage");

endmodule

`default_nettype wire
